>>> rtl/lzot_pkg.sv
// Package for the layer z-order table: widths, codes and the
// controller/datapath command and status structs. No dependencies.
package lzot_pkg;

  localparam int unsigned LAYERS_DEF = 256;   // default number of layer slots
  localparam int unsigned ID_W       = 8;     // layer id width
  localparam int unsigned HGT_W      = 9;     // height width on the ports and in storage
  localparam int unsigned CALC_W     = HGT_W + 1; // internal height math, room for top+1
  localparam int unsigned CNT_W      = 9;     // shift count, up to 256 moves
  localparam int unsigned STATUS_W   = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_SET   = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

  // which kind of result the datapath builds on a load
  typedef enum logic [1:0] {
    RES_ALLOC,
    RES_FULL,
    RES_BAD_ID,
    RES_MOVE
  } res_kind_e;

  typedef struct packed {
    logic      accept;    // latch the input item, restart the slot scan
    logic      scan_inc;  // advance the free-slot scan
    logic      hread;     // read the addressed layer's height
    logic      plan;      // clamp height, set up the shift
    logic      shift;     // run one shift step
    logic      load;      // commit final writes, load the result register
    res_kind_e kind;
  } lzot_cmd_t;

  typedef struct packed {
    logic scan_hit;    // current scan slot is free
    logic scan_last;   // current scan slot is the last one
    logic id_ok;       // addressed layer exists and is in use
    logic shift_done;  // no reads left, no write pending
    logic out_free;    // result register can take a new item
  } lzot_stat_t;

endpackage

>>> rtl/lzot_if.sv
// Channel interfaces of the layer z-order table: request and result items
// with valid/ready. Depends on lzot_pkg.
interface lzot_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic [lzot_pkg::ID_W-1:0]            layer_id;
  logic signed [lzot_pkg::HGT_W-1:0]    new_height;

  modport source (output valid, output opcode, output layer_id, output new_height,
                  input ready);
  modport sink   (input valid, input opcode, input layer_id, input new_height,
                  output ready);
endinterface

interface lzot_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [lzot_pkg::STATUS_W-1:0]        status;
  logic [lzot_pkg::ID_W-1:0]            result_id;
  logic signed [lzot_pkg::HGT_W-1:0]    applied_height;
  logic signed [lzot_pkg::HGT_W-1:0]    top_height;

  modport source (output valid, output status, output result_id, output applied_height,
                  output top_height, input ready);
  modport sink   (input valid, input status, input result_id, input applied_height,
                  input top_height, output ready);
endinterface

>>> rtl/lzot_ctrl.sv
// Sequencer of the layer z-order table: scan for an allocate, or check,
// plan and shift for a set, then result load. Depends on lzot_pkg.
module lzot_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  input  lzot_pkg::lzot_stat_t stat_i,
  output lzot_pkg::lzot_cmd_t  cmd_o,
  output logic                 in_ready_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_PLAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  lzot_pkg::res_kind_e kind_q, kind_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    kind_d         = kind_q;
    cmd_o          = '0;
    cmd_o.kind     = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (in_op_i)
            lzot_pkg::OP_ALLOC: state_d = ST_SCAN;
            lzot_pkg::OP_SET:   state_d = ST_CHECK;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_hit) begin
          kind_d  = lzot_pkg::RES_ALLOC;
          state_d = ST_DONE;
        end else if (stat_i.scan_last) begin
          kind_d  = lzot_pkg::RES_FULL;
          state_d = ST_DONE;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      ST_CHECK: begin
        if (stat_i.id_ok) begin
          cmd_o.hread = 1'b1;
          state_d     = ST_PLAN;
        end else begin
          kind_d  = lzot_pkg::RES_BAD_ID;
          state_d = ST_DONE;
        end
      end
      ST_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (stat_i.shift_done) begin
          kind_d  = lzot_pkg::RES_MOVE;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= lzot_pkg::RES_ALLOC;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

>>> rtl/lzot_datapath.sv
// Datapath of the layer z-order table: in-use flags, height and order
// memories, shift engine and result register. Depends on lzot_pkg.
module lzot_datapath #(
  parameter int unsigned LAYERS = lzot_pkg::LAYERS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lzot_pkg::lzot_cmd_t                  cmd_i,
  output lzot_pkg::lzot_stat_t                 stat_o,
  input  logic [lzot_pkg::ID_W-1:0]            in_id_i,
  input  logic signed [lzot_pkg::HGT_W-1:0]    in_height_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lzot_pkg::STATUS_W-1:0]        out_status_o,
  output logic [lzot_pkg::ID_W-1:0]            out_id_o,
  output logic signed [lzot_pkg::HGT_W-1:0]    out_applied_o,
  output logic signed [lzot_pkg::HGT_W-1:0]    out_top_o
);

  localparam int unsigned ID_W    = lzot_pkg::ID_W;
  localparam int unsigned HGT_W   = lzot_pkg::HGT_W;
  localparam int unsigned CW      = lzot_pkg::CALC_W;
  localparam int unsigned CNT_W   = lzot_pkg::CNT_W;
  // ids travel in ID_W bits, so only that many slots are ever reachable
  localparam int unsigned IdLimit = (LAYERS < (1 << ID_W)) ? LAYERS : (1 << ID_W);
  localparam int unsigned IdxW    = $clog2(IdLimit);
  localparam logic signed [CW-1:0] NegOne = '1;
  localparam logic signed [CW-1:0] One    = CW'(1);

  // control state
  logic [IdLimit-1:0]    in_use_q;
  logic signed [CW-1:0]  top_q;
  logic [CNT_W-1:0]      left_q;
  logic                  wr_vld_q;
  logic                  out_valid_q;

  // payload state
  logic [IdxW-1:0]       scan_q;
  logic [ID_W-1:0]       id_q;
  logic [HGT_W-1:0]      req_q;
  logic [HGT_W-1:0]      hrd_q;
  logic [ID_W-1:0]       ord_rd_q;
  logic signed [CW-1:0]  rd_dst_q, wr_dst_q, h_q;
  logic                  dn_q, put_q, top_inc_q, top_dec_q;
  logic [lzot_pkg::STATUS_W-1:0] res_status_q;
  logic [ID_W-1:0]       res_id_q;
  logic [HGT_W-1:0]      res_applied_q, res_top_q;

  logic [HGT_W-1:0]      hgt_mem [IdLimit];
  logic [ID_W-1:0]       ord_mem [IdLimit];

  // plan logic
  logic signed [CW-1:0]  old_h, req_h, lim, h_clip, h_new, start, diff, src_pos, top_next;
  logic                  dn_d, put_d, tinc_d, tdec_d;
  logic                  rd_issue;

  // write ports
  logic                  hw_en, ow_en;
  logic [IdxW-1:0]       hw_addr, ow_addr;
  logic [HGT_W-1:0]      hw_data;
  logic [ID_W-1:0]       ow_data;

  logic [lzot_pkg::STATUS_W-1:0] res_status_d;
  logic [ID_W-1:0]       res_id_d;
  logic [HGT_W-1:0]      res_applied_d;

  always_comb begin
    old_h  = {hrd_q[HGT_W-1], hrd_q};
    req_h  = {req_q[HGT_W-1], req_q};
    lim    = (old_h >= 0) ? top_q : top_q + One;
    h_clip = (req_h > lim) ? lim : req_h;
    h_new  = (h_clip < NegOne) ? NegOne : h_clip;
    start  = old_h;
    diff   = '0;
    dn_d   = 1'b0;
    put_d  = 1'b0;
    tinc_d = 1'b0;
    tdec_d = 1'b0;
    if (old_h > h_new) begin
      if (h_new >= 0) begin
        // move down: layers between shift up one
        diff  = old_h - h_new;
        dn_d  = 1'b1;
        put_d = 1'b1;
      end else begin
        // hide: layers above close the gap
        diff   = top_q - old_h;
        tdec_d = 1'b1;
      end
    end else if (old_h < h_new) begin
      if (old_h >= 0) begin
        // move up: layers between shift down one
        diff  = h_new - old_h;
        put_d = 1'b1;
      end else begin
        // insert from hidden: layers from h upward shift up one
        start  = top_q + One;
        diff   = top_q + One - h_new;
        dn_d   = 1'b1;
        put_d  = 1'b1;
        tinc_d = 1'b1;
      end
    end
  end

  // each shift step copies entry dst+step into dst
  assign src_pos  = dn_q ? rd_dst_q - One : rd_dst_q + One;
  assign rd_issue = cmd_i.shift && (left_q != '0);
  assign top_next = top_inc_q ? top_q + One : (top_dec_q ? top_q - One : top_q);

  always_comb begin
    hw_en   = 1'b0;
    hw_addr = ord_rd_q[IdxW-1:0];
    hw_data = wr_dst_q[HGT_W-1:0];
    ow_en   = 1'b0;
    ow_addr = wr_dst_q[IdxW-1:0];
    ow_data = ord_rd_q;
    if (cmd_i.shift && wr_vld_q) begin
      hw_en = 1'b1;
      ow_en = 1'b1;
    end else if (cmd_i.load && cmd_i.kind == lzot_pkg::RES_ALLOC) begin
      hw_en   = 1'b1;
      hw_addr = scan_q;
      hw_data = '1;
    end else if (cmd_i.load && cmd_i.kind == lzot_pkg::RES_MOVE) begin
      hw_en   = 1'b1;
      hw_addr = id_q[IdxW-1:0];
      hw_data = h_q[HGT_W-1:0];
      ow_en   = put_q;
      ow_addr = h_q[IdxW-1:0];
      ow_data = id_q;
    end
  end

  always_comb begin
    unique case (cmd_i.kind)
      lzot_pkg::RES_ALLOC: begin
        res_status_d  = lzot_pkg::STATUS_OK;
        res_id_d      = ID_W'(scan_q);
        res_applied_d = '1;
      end
      lzot_pkg::RES_FULL: begin
        res_status_d  = lzot_pkg::STATUS_NO_FREE;
        res_id_d      = '0;
        res_applied_d = '0;
      end
      lzot_pkg::RES_BAD_ID: begin
        res_status_d  = lzot_pkg::STATUS_NOT_USED;
        res_id_d      = id_q;
        res_applied_d = '1;
      end
      lzot_pkg::RES_MOVE: begin
        res_status_d  = lzot_pkg::STATUS_OK;
        res_id_d      = id_q;
        res_applied_d = h_q[HGT_W-1:0];
      end
      default: begin
        res_status_d  = lzot_pkg::STATUS_OK;
        res_id_d      = '0;
        res_applied_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      top_q       <= NegOne;
      left_q      <= '0;
      wr_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.plan) begin
        left_q   <= diff[CNT_W-1:0];
        wr_vld_q <= 1'b0;
      end else if (cmd_i.shift) begin
        wr_vld_q <= rd_issue;
        if (rd_issue) begin
          left_q <= left_q - 1'b1;
        end
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
        if (cmd_i.kind == lzot_pkg::RES_ALLOC) begin
          in_use_q[scan_q] <= 1'b1;
        end
        if (cmd_i.kind == lzot_pkg::RES_MOVE) begin
          top_q <= top_next;
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      id_q   <= in_id_i;
      req_q  <= in_height_i;
      scan_q <= '0;
    end
    if (cmd_i.scan_inc) begin
      scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.hread) begin
      hrd_q <= hgt_mem[id_q[IdxW-1:0]];
    end
    if (cmd_i.plan) begin
      rd_dst_q  <= start;
      h_q       <= h_new;
      dn_q      <= dn_d;
      put_q     <= put_d;
      top_inc_q <= tinc_d;
      top_dec_q <= tdec_d;
    end
    if (rd_issue) begin
      ord_rd_q <= ord_mem[src_pos[IdxW-1:0]];
      wr_dst_q <= rd_dst_q;
      rd_dst_q <= src_pos;
    end
    if (cmd_i.load) begin
      res_status_q  <= res_status_d;
      res_id_q      <= res_id_d;
      res_applied_q <= res_applied_d;
      res_top_q     <= (cmd_i.kind == lzot_pkg::RES_MOVE) ? top_next[HGT_W-1:0]
                                                          : top_q[HGT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) begin
      hgt_mem[hw_addr] <= hw_data;
    end
    if (ow_en) begin
      ord_mem[ow_addr] <= ow_data;
    end
  end

  always_comb begin
    stat_o.scan_hit   = !in_use_q[scan_q];
    stat_o.scan_last  = (scan_q == IdxW'(IdLimit - 1));
    stat_o.id_ok      = (32'(id_q) < LAYERS) && in_use_q[id_q[IdxW-1:0]];
    stat_o.shift_done = (left_q == '0) && !wr_vld_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = res_status_q;
  assign out_id_o      = res_id_q;
  assign out_applied_o = res_applied_q;
  assign out_top_o     = res_top_q;

endmodule

>>> rtl/layer_z_order_table_top.sv
// Top level of the layer z-order table: sequencer plus datapath.
// Depends on lzot_pkg, lzot_if, lzot_ctrl and lzot_datapath.
//
// Usage:
//   req_i carries one item per valid/ready handshake: opcode 0 allocates the
//   lowest free layer slot (hidden, height -1); opcode 1 sets the height of
//   layer_id, clamped to -1..top (visible layer) or -1..top+1 (hidden layer).
//   rsp_o returns exactly one result item per request: status, the layer id,
//   the height the layer now holds and the current top height.
// Timing:
//   One item is in work at a time; req_i.ready is high only while idle.
//   Allocate scans slots from 0 upward (up to min(LAYERS,256) of them);
//   set height reads the layer's height, plans the move, then shifts the
//   order table entries in between; the shift engine moves one entry per
//   cycle over the order memory's single read and single write port.
//   An unknown or unused layer returns straight after its check, no shift.
// Reset:
//   Asynchronous, active low. All slots free, no layer visible (top -1).
//   The order memory is not cleared; only written entries are ever read.
// Back pressure:
//   The result sits in an output register until rsp_o.ready; a new request
//   is accepted meanwhile and waits at its end for that register to free.
module layer_z_order_table_top #(
  parameter int unsigned LAYERS = lzot_pkg::LAYERS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  lzot_req_if.sink        req_i,
  lzot_rsp_if.source      rsp_o
);

  lzot_pkg::lzot_cmd_t  cmd;
  lzot_pkg::lzot_stat_t stat;
  logic                 in_ready;

  // sequencer: decides what the datapath does each cycle
  lzot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_op_i    (req_i.opcode),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  // tables, shift engine and result register
  lzot_datapath #(
    .LAYERS (LAYERS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_id_i       (req_i.layer_id),
    .in_height_i   (req_i.new_height),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .out_status_o  (rsp_o.status),
    .out_id_o      (rsp_o.result_id),
    .out_applied_o (rsp_o.applied_height),
    .out_top_o     (rsp_o.top_height)
  );

  assign req_i.ready = in_ready;

endmodule
